### rtl/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and register codes for the open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int unsigned HashMult = 151;

    // register indexes
    localparam logic [1:0] RegHashMode  = 2'd0;
    localparam logic [1:0] RegProbeMode = 2'd1;
    localparam logic [1:0] RegSlotsUsed = 2'd2;

    // probe schemes
    localparam logic [1:0] ProbeLinear   = 2'd0;
    localparam logic [1:0] ProbeQuad     = 2'd1;
    localparam logic [1:0] ProbeOverflow = 2'd2;

    // request operations
    localparam logic OpInsert = 1'b0;
    localparam logic OpQuery  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] data_out;
        logic [9:0]  slot;
    } t_rsp;

endpackage

### rtl/oaht_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_req_if / oaht_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface oaht_req_if;
    logic          valid;
    logic          ready;
    oaht_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface oaht_rsp_if;
    logic          valid;
    logic          ready;
    oaht_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/oaht_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_hash
// Character-serial hash: each character is folded in, then reduced modulo m before the next.
// ----------------------------------------------------------------------------
module oaht_hash #(
    parameter int unsigned KEY_CHARS = 8,
    parameter int unsigned AW        = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_mult,
    input  logic [63:0]   i_key,
    input  logic [3:0]    i_len,
    input  logic [AW:0]   i_mod,
    output logic          o_done,
    output logic [AW-1:0] o_hash
);
    // h < m, c < 256 => h*151+c < 151*m+256; reduce by successive subtraction
    localparam int unsigned PW = AW + 10;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED} t_state;

    t_state         r_state;
    logic [AW:0]    r_h;
    logic [PW-1:0]  r_acc;
    logic [3:0]     r_idx;
    logic [3:0]     r_len;
    logic [63:0]    r_key;
    logic [PW-1:0]  r_sub;
    logic           r_mult;
    logic [3:0]     r_shift;
    logic [7:0]     w_char;

    assign w_char = r_key[8 * r_idx[2:0] +: 8];
    assign o_hash = r_h[AW-1:0];

    // shift-subtract reduction: subtract m<<k for k from 8 down to 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_h    <= '0;
                        r_idx  <= '0;
                        r_key  <= i_key;
                        r_mult <= i_mult;
                        r_len  <= (i_len > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : i_len;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_idx == r_len) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (r_mult)
                            r_acc <= PW'(r_h) * PW'(oaht_pkg::HashMult) + PW'(w_char);
                        else
                            r_acc <= PW'(r_h) + PW'(w_char);
                        r_sub   <= PW'(i_mod) << 8;
                        r_shift <= 4'd8;
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_acc >= r_sub)
                        r_acc <= r_acc - r_sub;
                    if (r_shift == 4'd0) begin
                        r_h     <= (r_acc >= r_sub) ? (AW+1)'(r_acc - r_sub)
                                                    : (AW+1)'(r_acc);
                        r_state <= S_MUL;
                    end else begin
                        r_sub   <= r_sub >> 1;
                        r_shift <= r_shift - 4'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Key/value table with open addressing: linear, quadratic or overflow probing.
// ----------------------------------------------------------------------------
// channel | dir | carries
// req     | in  | op, key, key_length, value
// rsp     | out | ok, data_out, slot
// apb     | in  | hash_mode, probe_mode, slots_used
//
// The hash takes the key one character at a time: a multiply step, then 9
// reduce steps. Probing then visits up to S slots, each in turn via the
// address, read and evaluate states; a quadratic step first reduces
// a square modulo S. After reset a clearing pass empties the valid store.
// One request at a time; one finished result may wait at the output while
// the next request is worked on, which then holds until the output is free.
module open_addressing_hash_table #(
    parameter int unsigned TABLE_DEPTH    = 1024,
    parameter int unsigned OVERFLOW_SLOTS = 64,
    parameter int unsigned KEY_CHARS      = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oaht_req_if.sink    i_req,
    oaht_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned EW = 4 + 64 + 32;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_INIT, S_ADDR, S_SQ, S_READ, S_EVAL, S_OVF, S_DONE
    } t_state;

    t_state        r_state;

    // configuration
    logic        r_hash_mode;
    logic [1:0]  r_probe_mode;
    logic [10:0] r_slots_used;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            oaht_pkg::RegHashMode:  prdata = {31'd0, r_hash_mode};
            oaht_pkg::RegProbeMode: prdata = {30'd0, r_probe_mode};
            oaht_pkg::RegSlotsUsed: prdata = {21'd0, r_slots_used};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode  <= 1'b1;
            r_probe_mode <= oaht_pkg::ProbeLinear;
            r_slots_used <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                oaht_pkg::RegHashMode:  r_hash_mode  <= pwdata[0];
                oaht_pkg::RegProbeMode: r_probe_mode <= pwdata[1:0];
                oaht_pkg::RegSlotsUsed: r_slots_used <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // clamped slot count and primary area size
    logic [AW:0] w_s, w_p;
    always_comb begin
        if (r_slots_used < 11'd2) w_s = (AW+1)'(2);
        else if (32'(r_slots_used) > TABLE_DEPTH) w_s = (AW+1)'(TABLE_DEPTH);
        else w_s = (AW+1)'(r_slots_used);
        w_p = (32'(w_s) > OVERFLOW_SLOTS) ? w_s - (AW+1)'(OVERFLOW_SLOTS) : (AW+1)'(1);
    end
    logic w_ovf;
    assign w_ovf = (r_probe_mode == oaht_pkg::ProbeOverflow);

    // memories: entry store and valid store
    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic          r_vmem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;
    logic          r_rdv;
    logic [AW-1:0] r_addr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic          w_wv;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr]  <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (w_we || r_state == S_CLEAR) begin
            r_vmem[w_waddr] <= w_wv;
        end
        r_rdv <= r_vmem[r_addr];
    end

    // request state
    oaht_pkg::t_req r_req;
    logic [63:0]   w_key;
    logic [3:0]    w_len;
    logic [AW:0]   r_home;
    logic [AW:0]   r_i;
    logic [AW:0]   r_cur;
    logic [2*AW+1:0] r_sq;
    logic [AW:0]   r_q;
    logic [AW:0]   r_cnt;
    logic          r_hstart;
    logic          w_hdone;
    logic [AW-1:0] w_hash;
    logic          r_ovf_scan;
    oaht_pkg::t_rsp r_res;
    oaht_pkg::t_rsp r_rsp;
    logic          r_rsp_valid;
    logic [AW:0]   w_k;

    assign w_len = (r_req.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : r_req.key_length;
    assign w_key = (w_len >= 4'd8) ? r_req.key
                 : r_req.key & ((64'd1 << {w_len[2:0], 3'b000}) - 64'd1);
    assign w_k   = (r_i + (AW+1)'(1)) >> 1;

    oaht_hash #(.KEY_CHARS(KEY_CHARS), .AW(AW)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hstart),
        .i_mult  (r_hash_mode),
        .i_key   (r_req.key),
        .i_len   (r_req.key_length),
        .i_mod   (w_ovf ? w_p : w_s),
        .o_done  (w_hdone),
        .o_hash  (w_hash)
    );

    logic w_match;
    assign w_match = r_rdv && (r_rd[EW-1 -: 4] == w_len)
                  && (r_rd[EW-5 -: 64] == w_key);

    // write port: clearing pass or insert
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = {w_len, w_key, r_req.value};
        w_wv    = 1'b0;
        if (r_state == S_EVAL && !r_rdv && r_req.op == oaht_pkg::OpInsert) begin
            w_we    = 1'b1;
            w_waddr = r_cur[AW-1:0];
            w_wv    = 1'b1;
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_hstart    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_hstart <= 1'b0;
            // output register: load a finished result once free
            if (r_state == S_DONE && (!r_rsp_valid || o_rsp.ready)) begin
                r_rsp       <= r_res;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + (AW+1)'(1);
                    if (32'(r_cnt) == TABLE_DEPTH - 1)
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req    <= i_req.payload;
                        r_hstart <= 1'b1;
                        r_state  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hdone) begin
                        r_home     <= {1'b0, w_hash};
                        r_cur      <= {1'b0, w_hash};
                        r_addr     <= w_hash;
                        r_i        <= '0;
                        r_ovf_scan <= 1'b0;
                        r_state    <= S_READ;
                    end
                end
                S_ADDR: begin
                    // next probe position
                    if (w_ovf) begin
                        r_cur   <= r_i;
                        r_addr  <= r_i[AW-1:0];
                        r_state <= S_READ;
                    end else if (r_probe_mode == oaht_pkg::ProbeQuad) begin
                        r_sq    <= (2*AW+2)'(w_k) * (2*AW+2)'(w_k);
                        r_state <= S_SQ;
                    end else begin
                        r_cur   <= (r_home + r_i >= w_s) ? r_home + r_i - w_s : r_home + r_i;
                        r_addr  <= AW'((r_home + r_i >= w_s) ? r_home + r_i - w_s
                                                             : r_home + r_i);
                        r_state <= S_READ;
                    end
                end
                S_SQ: begin
                    // reduce square modulo S one subtraction at a time
                    if (r_sq >= (2*AW+2)'(w_s)) begin
                        if (r_sq >= ((2*AW+2)'(w_s) << AW))
                            r_sq <= r_sq - ((2*AW+2)'(w_s) << AW);
                        else if (r_sq >= ((2*AW+2)'(w_s) << (AW/2)))
                            r_sq <= r_sq - ((2*AW+2)'(w_s) << (AW/2));
                        else
                            r_sq <= r_sq - (2*AW+2)'(w_s);
                    end else begin
                        r_q     <= (AW+1)'(r_sq);
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    if (r_i[0]) begin
                        r_cur  <= (r_home + r_q >= w_s) ? r_home + r_q - w_s : r_home + r_q;
                        r_addr <= AW'((r_home + r_q >= w_s) ? r_home + r_q - w_s
                                                            : r_home + r_q);
                    end else begin
                        r_cur  <= (r_home >= r_q) ? r_home - r_q : r_home + w_s - r_q;
                        r_addr <= AW'((r_home >= r_q) ? r_home - r_q : r_home + w_s - r_q);
                    end
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    r_res.ok       <= 1'b0;
                    r_res.data_out <= '0;
                    r_res.slot     <= '0;
                    if (!w_ovf) begin
                        if (!r_rdv) begin
                            if (r_req.op == oaht_pkg::OpInsert) begin
                                r_res.ok   <= 1'b1;
                                r_res.slot <= 10'(r_cur);
                            end
                            r_state <= S_DONE;
                        end else if (r_req.op == oaht_pkg::OpQuery && w_match) begin
                            r_res.ok       <= 1'b1;
                            r_res.data_out <= r_rd[31:0];
                            r_res.slot     <= 10'(r_cur);
                            r_state        <= S_DONE;
                        end else if (r_i + (AW+1)'(1) >= w_s) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= r_i + (AW+1)'(1);
                            r_state <= S_ADDR;
                        end
                    end else begin
                        if (!r_rdv && (r_req.op == oaht_pkg::OpInsert || !r_ovf_scan)) begin
                            if (r_req.op == oaht_pkg::OpInsert) begin
                                r_res.ok   <= 1'b1;
                                r_res.slot <= 10'(r_cur);
                            end
                            r_state <= S_DONE;
                        end else if (r_req.op == oaht_pkg::OpQuery && w_match) begin
                            r_res.ok       <= 1'b1;
                            r_res.data_out <= r_rd[31:0];
                            r_res.slot     <= 10'(r_cur);
                            r_state        <= S_DONE;
                        end else begin
                            r_state <= S_OVF;
                        end
                    end
                end
                S_OVF: begin
                    // walk the overflow area from p upwards
                    if (!r_ovf_scan) begin
                        r_ovf_scan <= 1'b1;
                        r_i        <= w_p;
                        r_state    <= (w_p < w_s) ? S_ADDR : S_DONE;
                    end else if (r_i + (AW+1)'(1) < w_s) begin
                        r_i     <= r_i + (AW+1)'(1);
                        r_state <= S_ADDR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_rsp_valid || o_rsp.ready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/oaht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module oaht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_rsp_ok,
    input logic [9:0] i_rsp_slot
);
    // result holds while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid) else $error("result dropped");
    // failed request reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ok |-> i_rsp_slot == 10'd0) else $error("slot on failure");
    // no new request while one is in flight
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready) else $error("overlapping requests");
endmodule

bind open_addressing_hash_table oaht_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_ok    (o_rsp.payload.ok),
    .i_rsp_slot  (o_rsp.payload.slot)
);

### tb/tb_open_addressing_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_table
// Self-checking bench for the open addressing hash table. Requests go in over
// the valid/ready request channel. A table model kept inside the bench works
// out each result, and a checker compares every returned result with it.
// Directed tests cover the extreme keys and lengths, a full table, every
// probe scheme and slot counts outside the legal range. Random phases then
// run inserts and queries on a shared key pool under several settings.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_table;

    localparam int unsigned DEPTH      = 1024;
    localparam int unsigned OVF_SLOTS  = 64;
    localparam int unsigned MAX_CHARS  = 8;
    localparam int unsigned CYCLE_CAP  = 6000000;
    localparam int unsigned POOL_SIZE  = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    oaht_req_if req_ch();
    oaht_rsp_if rsp_ch();

    open_addressing_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model copy of the registers and the slot stores
    logic        cfg_hash_mode;
    logic [1:0]  cfg_probe_mode;
    logic [10:0] cfg_slots_used;
    logic        tbl_valid [DEPTH];
    logic [63:0] tbl_key   [DEPTH];
    logic [3:0]  tbl_len   [DEPTH];
    logic [31:0] tbl_value [DEPTH];

    oaht_pkg::t_rsp pending_results[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned request_count;
    int unsigned result_count;
    int unsigned found_count;
    int unsigned hold_cycles;
    bit          no_idle;

    logic [63:0] pool_key [POOL_SIZE];
    logic [3:0]  pool_len [POOL_SIZE];

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] key_mask(input int unsigned len);
        if (len >= MAX_CHARS) return '1;
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function automatic int unsigned hash_of(input logic [63:0] key, input int unsigned len,
                                            input int unsigned modulus);
        longint unsigned h;
        longint unsigned ch;
        h = 0;
        for (int unsigned n = 0; n < len; n++) begin
            ch = (key >> (8 * n)) & 64'hFF;
            if (cfg_hash_mode) h = (h * oaht_pkg::HashMult + ch) % modulus;
            else h = (h + ch) % modulus;
        end
        return int'(h);
    endfunction

    function automatic bit slot_holds(input int unsigned s, input logic [63:0] key,
                                      input logic [3:0] len);
        return tbl_valid[s] && tbl_len[s] == len && tbl_key[s] == key;
    endfunction

    // expected result of one request, updating the model table
    function automatic oaht_pkg::t_rsp table_lookup(input oaht_pkg::t_req r);
        oaht_pkg::t_rsp res;
        int unsigned len;
        int unsigned s;
        int unsigned p;
        int unsigned home;
        int unsigned pos;
        int unsigned cand;
        int unsigned k;
        int unsigned q;
        logic [63:0] key;
        bit          hit;
        hit = 1'b0;
        pos = 0;
        len = (r.key_length > MAX_CHARS) ? MAX_CHARS : r.key_length;
        key = r.key & key_mask(len);
        s = cfg_slots_used;
        if (s < 2) s = 2;
        if (s > DEPTH) s = DEPTH;
        if (cfg_probe_mode == oaht_pkg::ProbeOverflow) begin
            p = (s > OVF_SLOTS) ? s - OVF_SLOTS : 1;
            home = hash_of(key, len, p);
            if (r.op == oaht_pkg::OpInsert) begin
                if (!tbl_valid[home]) begin
                    pos = home;
                    hit = 1'b1;
                end else begin
                    for (int unsigned n = p; n < s && !hit; n++) begin
                        if (!tbl_valid[n]) begin
                            pos = n;
                            hit = 1'b1;
                        end
                    end
                end
            end else if (tbl_valid[home]) begin
                if (slot_holds(home, key, 4'(len))) begin
                    pos = home;
                    hit = 1'b1;
                end else begin
                    for (int unsigned n = p; n < s && !hit; n++) begin
                        if (slot_holds(n, key, 4'(len))) begin
                            pos = n;
                            hit = 1'b1;
                        end
                    end
                end
            end
        end else begin
            home = hash_of(key, len, s);
            for (int unsigned n = 0; n < s; n++) begin
                if (n == 0) cand = home;
                else if (cfg_probe_mode != oaht_pkg::ProbeQuad) cand = (home + n) % s;
                else begin
                    k = (n + 1) / 2;
                    q = (k * k) % s;
                    cand = (n & 1) ? (home + q) % s : (home + s - q) % s;
                end
                if (!tbl_valid[cand]) begin
                    if (r.op == oaht_pkg::OpInsert) begin
                        pos = cand;
                        hit = 1'b1;
                    end
                    break;
                end
                if (r.op == oaht_pkg::OpQuery && slot_holds(cand, key, 4'(len))) begin
                    pos = cand;
                    hit = 1'b1;
                    break;
                end
            end
        end
        res = '0;
        res.ok = hit;
        if (hit) begin
            if (r.op == oaht_pkg::OpInsert) begin
                tbl_valid[pos] = 1'b1;
                tbl_key[pos]   = key;
                tbl_len[pos]   = 4'(len);
                tbl_value[pos] = r.value;
            end else begin
                res.data_out = tbl_value[pos];
            end
            res.slot = 10'(pos);
        end
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: ok %0b data %0h slot %0d",
                       rsp_ch.payload.ok, rsp_ch.payload.data_out, rsp_ch.payload.slot);
                error_count++;
            end else begin
                automatic oaht_pkg::t_rsp want = pending_results.pop_front();
                if (want.ok) found_count++;
                if (rsp_ch.payload.ok !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, rsp_ch.payload.ok);
                    error_count++;
                end
                if (rsp_ch.payload.data_out !== want.data_out) begin
                    $error("data_out: expected %0h, got %0h",
                           want.data_out, rsp_ch.payload.data_out);
                    error_count++;
                end
                if (rsp_ch.payload.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_ch.payload.slot);
                    error_count++;
                end
            end
        end
    end

    // result receiver with random stalls and an optional long hold-off
    initial begin
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // send one request, predicting its result at acceptance
    task automatic send_request(input logic op, input logic [63:0] key,
                                input logic [3:0] len, input logic [31:0] value);
        oaht_pkg::t_req r;
        int unsigned gap;
        r.op = op;
        r.key = key;
        r.key_length = len;
        r.value = value;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(table_lookup(r));
        request_count++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            oaht_pkg::RegHashMode:  cfg_hash_mode  = data[0];
            oaht_pkg::RegProbeMode: cfg_probe_mode = data[1:0];
            oaht_pkg::RegSlotsUsed: cfg_slots_used = data[10:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic hmode, input logic [1:0] pmode,
                            input logic [10:0] slots);
        drain_results();
        write_register(oaht_pkg::RegHashMode, {31'd0, hmode});
        write_register(oaht_pkg::RegProbeMode, {30'd0, pmode});
        write_register(oaht_pkg::RegSlotsUsed, {21'd0, slots});
    endtask

    // extremes of the fields on the reset settings
    task automatic test_field_extremes();
        send_request(oaht_pkg::OpInsert, 64'd0, 4'd0, 32'h8000_0000);
        send_request(oaht_pkg::OpInsert, '1, 4'd8, 32'h7FFF_FFFF);
        send_request(oaht_pkg::OpInsert, 64'h0041_0000_4242, 4'd15, 32'hFFFF_FFFF);
        send_request(oaht_pkg::OpInsert, 64'hFF00_0041, 4'd3, 32'h1234_5678);
        send_request(oaht_pkg::OpQuery, 64'hDEAD_BEEF, 4'd0, 32'd0);
        send_request(oaht_pkg::OpQuery, '1, 4'd8, 32'd0);
        send_request(oaht_pkg::OpQuery, 64'hFFFF_0041_0000_4242, 4'd8, 32'd0);
        send_request(oaht_pkg::OpQuery, 64'h0000_0041, 4'd3, 32'd0);
        send_request(oaht_pkg::OpQuery, 64'hFF00_0041, 4'd3, 32'd0);
        send_request(oaht_pkg::OpQuery, 64'h4142_4344, 4'd4, 32'd0);
    endtask

    // tiny tables with colliding keys, the linear one filled to overflow, each probe scheme
    task automatic test_full_tables();
        set_mode(1'b0, oaht_pkg::ProbeLinear, 11'd3);
        for (int n = 0; n < 4; n++)
            send_request(oaht_pkg::OpInsert, 64'(n + 16), 4'd1, 32'(n));
        send_request(oaht_pkg::OpQuery, 64'h99, 4'd1, 32'd0);
        set_mode(1'b1, oaht_pkg::ProbeQuad, 11'd5);
        for (int n = 0; n < 3; n++)
            send_request(oaht_pkg::OpInsert, 64'(n * 5 + 1), 4'd2, 32'(n));
        send_request(oaht_pkg::OpQuery, 64'd11, 4'd2, 32'd0);
        set_mode(1'b0, oaht_pkg::ProbeOverflow, 11'd66);
        send_request(oaht_pkg::OpInsert, 64'h7, 4'd1, 32'd70);
        send_request(oaht_pkg::OpInsert, 64'h0700, 4'd2, 32'd71);
        send_request(oaht_pkg::OpQuery, 64'h0700, 4'd2, 32'd0);
        send_request(oaht_pkg::OpQuery, 64'h0701, 4'd2, 32'd0);
    endtask

    // slot counts outside the legal range and the unused probe code
    task automatic test_odd_settings();
        set_mode(1'b1, 2'd3, 11'd1);
        for (int n = 0; n < 3; n++) send_request(oaht_pkg::OpInsert, 64'(n), 4'd1, 32'(n));
        send_request(oaht_pkg::OpQuery, 64'd1, 4'd1, 32'd0);
        set_mode(1'b1, oaht_pkg::ProbeOverflow, 11'd2047);
        send_request(oaht_pkg::OpInsert, 64'h5A5A, 4'd2, 32'hCAFE);
        send_request(oaht_pkg::OpQuery, 64'h5A5A, 4'd2, 32'd0);
    endtask

    function automatic void fill_key_pool();
        for (int n = 0; n < POOL_SIZE; n++) begin
            pool_key[n] = {$urandom, $urandom};
            pool_len[n] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        end
    endfunction

    // random inserts and queries over a shared key pool
    task automatic test_random_phase(input logic hmode, input logic [1:0] pmode,
                                     input logic [10:0] slots, input int unsigned count);
        int unsigned pick;
        logic [63:0] key;
        logic [3:0]  len;
        set_mode(hmode, pmode, slots);
        fill_key_pool();
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            key = pool_key[pick];
            len = pool_len[pick];
            if ($urandom_range(0, 7) == 0) begin
                key = {$urandom, $urandom};
                len = 4'($urandom_range(0, 15));
            end
            send_request(logic'($urandom_range(0, 1)), key, len, $urandom);
        end
    endtask

    // long receiver hold-off while requests keep coming, then a full pause
    task automatic test_backpressure();
        set_mode(1'b1, oaht_pkg::ProbeLinear, 11'd32);
        no_idle = 1'b1;
        hold_cycles = 800;
        for (int n = 0; n < 12; n++)
            send_request(oaht_pkg::OpInsert, {$urandom, $urandom}, 4'd8, $urandom);
        no_idle = 1'b0;
        drain_results();
        for (int n = 0; n < 6; n++)
            send_request(oaht_pkg::OpQuery, {$urandom, $urandom}, 4'd8, 32'd0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        error_count = 0;
        cycle_count = 0;
        request_count = 0;
        result_count = 0;
        found_count = 0;
        hold_cycles = 0;
        no_idle = 1'b0;
        cfg_hash_mode = 1'b1;
        cfg_probe_mode = oaht_pkg::ProbeLinear;
        cfg_slots_used = 11'd1024;
        for (int n = 0; n < DEPTH; n++) begin
            tbl_valid[n] = 1'b0;
            tbl_key[n] = '0;
            tbl_len[n] = '0;
            tbl_value[n] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_full_tables();
        test_odd_settings();
        test_backpressure();
        test_random_phase(1'b0, oaht_pkg::ProbeLinear,   11'd2,    40);
        test_random_phase(1'b1, oaht_pkg::ProbeQuad,     11'd13,   60);
        test_random_phase(1'b0, oaht_pkg::ProbeQuad,     11'd16,   50);
        test_random_phase(1'b1, oaht_pkg::ProbeOverflow, 11'd80,   60);
        test_random_phase(1'b0, oaht_pkg::ProbeOverflow, 11'd20,   50);
        no_idle = 1'b1;
        test_random_phase(1'b1, oaht_pkg::ProbeLinear,   11'd37,   50);
        no_idle = 1'b0;
        test_random_phase(1'b0, oaht_pkg::ProbeLinear,   11'd1024, 60);
        test_random_phase(1'b1, oaht_pkg::ProbeQuad,     11'd1024, 50);
        test_random_phase(1'b1, oaht_pkg::ProbeOverflow, 11'd1024, 50);
        test_random_phase(1'b0, oaht_pkg::ProbeQuad,     11'd7,    40);
        drain_results();

        $display("%0d requests sent, %0d results checked (%0d with ok set)",
                 request_count, result_count, found_count);
        $display("all probe schemes and both hashes, table sizes from 2 to 1024 slots");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
